// File: design/lgs_pkg.sv
// Shared constants and types of the life grid step block.
package lgs_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = 64;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int CNT_W    = ROW_AW + 1;
    localparam int CFG_W    = 7;

    typedef logic [ROW_W-1:0] t_row;
    typedef logic [1:0]       t_req;

    // request and acknowledge codes
    localparam t_req REQ_WRITE   = 2'd0;
    localparam t_req REQ_READ    = 2'd1;
    localparam t_req REQ_ADVANCE = 2'd2;
    localparam t_req REQ_BAD     = 2'd3;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // B3/S23 thresholds
    localparam logic [3:0] BIRTH_CNT   = 4'd3;
    localparam logic [3:0] SURVIVE_CNT = 4'd2;

endpackage

// File: design/life_automaton_grid_step.sv
// Top level of the life grid step block: request sequencer, grid RAM and row engine.
//
//  channel   | direction | accept            | payload
//  ----------+-----------+-------------------+-------------------------------------------
//  s stream  | in        | tvalid & tready   | tdata: row_index, row_bits_in; tuser: req_type
//  m stream  | out       | tvalid & tready   | tdata: row_bits_out; tuser: ack_kind
//  cfg write | in        | i_cfg_we          | index 0 grid_rows, 1 grid_cols
//
// Write and bad requests finish in the accepting cycle, a read waits on the
// registered RAM read, and an advance walks the rows in use: one row word
// is read from the grid RAM per cycle while the 64 cell lanes rewrite the row above.
// One request is in work at a time; a new one is taken while the last result
// still sits in the output register. Reset clears the per-row valid bits, so
// the grid reads as all dead at once, with no clearing sweep.
module life_automaton_grid_step import lgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [5:0] row_index, [69:6] row_bits_in, [71:70] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] row_bits_out
    output logic [1:0]  o_m_tuser    // [1:0] ack_kind
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_ADV  = 2'd2;

    logic [1:0]       r_state;
    logic [CFG_W-1:0] r_grid_rows;
    logic [CFG_W-1:0] r_grid_cols;

    logic [MAX_ROWS-1:0] r_valid;      // row written since reset
    logic                r_rd_valid;   // valid bit of the row in the read register
    logic                r_in_area;    // read request hit a row in use
    logic [CNT_W-1:0]    r_got;        // row index of the word arriving from RAM
    t_row                r_above;
    t_row                r_cur;

    // finished result waiting for the output register
    logic r_pend;
    t_row r_pend_bits;
    t_req r_pend_kind;

    logic r_out_valid;
    t_row r_out_bits;
    t_req r_out_kind;

    // effective sizes
    logic [CNT_W-1:0] w_rows;
    logic [CNT_W-1:0] w_cols;
    t_row             w_mask;

    assign w_rows = (r_grid_rows > CFG_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                     : CNT_W'(r_grid_rows);
    assign w_cols = (r_grid_cols > CFG_W'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                     : CNT_W'(r_grid_cols);

    for (genvar j = 0; j < ROW_W; j++) begin : g_mask
        assign w_mask[j] = (CNT_W'(j) < w_cols);
    end

    // input unpack
    t_req             w_kind;
    logic [ROW_AW-1:0] w_row_idx;
    t_row             w_row_bits;
    logic             w_accept;
    logic             w_req_in_area;

    assign w_kind        = i_s_tuser;
    assign w_row_idx     = i_s_tdata[ROW_AW-1:0];
    assign w_row_bits    = i_s_tdata[69:6];
    assign o_s_tready    = (r_state == ST_IDLE) && !r_pend;
    assign w_accept      = i_s_tvalid && o_s_tready;
    assign w_req_in_area = CNT_W'(w_row_idx) < w_rows;

    // RAM side
    logic              w_ram_we;
    logic [ROW_AW-1:0] w_ram_waddr;
    t_row              w_ram_wdata;
    logic [ROW_AW-1:0] w_ram_raddr;
    t_row              w_ram_rdata;
    t_row              w_rd_word;     // masked, dead when never written
    t_row              w_below;
    t_row              w_next_row;
    logic [CNT_W-1:0]  w_got_prev;
    logic [CNT_W-1:0]  w_got_next;
    logic              w_adv_wr;

    assign w_rd_word  = r_rd_valid ? (w_ram_rdata & w_mask) : '0;
    assign w_below    = (r_got < w_rows) ? w_rd_word : '0;
    assign w_got_prev = r_got - CNT_W'(1);
    assign w_got_next = r_got + CNT_W'(1);
    assign w_adv_wr   = (r_state == ST_ADV) && (r_got != '0);

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = w_row_idx;
        w_ram_wdata = w_row_bits & w_mask;
        if (w_accept && (w_kind == REQ_WRITE) && w_req_in_area) begin
            w_ram_we = 1'b1;
        end else if (w_adv_wr) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = w_got_prev[ROW_AW-1:0];
            w_ram_wdata = w_next_row;
        end
    end

    // while advancing, fetch the row after the one now arriving
    always_comb begin
        if (w_accept) begin
            w_ram_raddr = (w_kind == REQ_ADVANCE) ? '0 : w_row_idx;
        end else begin
            w_ram_raddr = w_got_next[ROW_AW-1:0];
        end
    end

    lgs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    lgs_row_next u_row_next (
        .i_above (r_above),
        .i_cur   (r_cur),
        .i_below (w_below),
        .i_mask  (w_mask),
        .o_next  (w_next_row)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= CFG_W'(50);
            r_grid_cols <= CFG_W'(60);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROWS: r_grid_rows <= i_cfg_wdata;
                CFG_COLS: r_grid_cols <= i_cfg_wdata;
                default:  r_grid_rows <= r_grid_rows;
            endcase
        end
    end

    // valid bits track rows written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ram_we) begin
            r_valid[w_ram_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[w_ram_raddr];
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            if (r_pend && (!r_out_valid || i_m_tready)) begin
                r_pend <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_pend_bits <= '0;
                        r_pend_kind <= w_kind;
                        r_in_area   <= w_req_in_area;
                        r_got       <= '0;
                        r_above     <= '0;
                        r_cur       <= '0;
                        if (w_kind == REQ_READ) begin
                            r_state <= ST_READ;
                        end else if (w_kind == REQ_ADVANCE && w_rows != '0) begin
                            r_state <= ST_ADV;
                        end else begin
                            // write, bad code or empty grid: done now
                            r_pend <= 1'b1;
                        end
                    end
                end
                ST_READ: begin
                    r_pend_bits <= r_in_area ? w_rd_word : '0;
                    r_pend      <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                ST_ADV: begin
                    r_above <= r_cur;
                    r_cur   <= w_below;
                    r_got   <= w_got_next;
                    if (r_got == w_rows) begin
                        r_pend  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && (!r_out_valid || i_m_tready)) begin
            r_out_valid <= 1'b1;
            r_out_bits  <= r_pend_bits;
            r_out_kind  <= r_pend_kind;
        end else if (r_out_valid && i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_bits;
    assign o_m_tuser  = r_out_kind;

endmodule

// File: design/lgs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lgs_lane.sv
// One cell lane: next state of a cell from its 3x3 neighborhood.
module lgs_lane import lgs_pkg::*; (
    input  logic [2:0] i_up,
    input  logic [2:0] i_mid,
    input  logic [2:0] i_down,
    output logic       o_next
);

    logic [3:0] w_cnt;

    assign w_cnt = 4'(i_up[0]) + 4'(i_up[1]) + 4'(i_up[2])
                 + 4'(i_mid[0]) + 4'(i_mid[2])
                 + 4'(i_down[0]) + 4'(i_down[1]) + 4'(i_down[2]);

    assign o_next = (w_cnt == BIRTH_CNT) || (i_mid[1] && (w_cnt == SURVIVE_CNT));

endmodule

// File: design/lgs_row_next.sv
// Row of cell lanes plus merge stage: builds the next row word under the column mask.
module lgs_row_next import lgs_pkg::*; (
    input  t_row i_above,
    input  t_row i_cur,
    input  t_row i_below,
    input  t_row i_mask,
    output t_row o_next
);

    // zero padding on both edges: the grid does not wrap
    logic [ROW_W+1:0] w_up_x;
    logic [ROW_W+1:0] w_mid_x;
    logic [ROW_W+1:0] w_dn_x;
    t_row             w_lane;

    assign w_up_x  = {1'b0, i_above, 1'b0};
    assign w_mid_x = {1'b0, i_cur,   1'b0};
    assign w_dn_x  = {1'b0, i_below, 1'b0};

    for (genvar j = 0; j < ROW_W; j++) begin : g_lane
        lgs_lane u_lane (
            .i_up   (w_up_x[j+2:j]),
            .i_mid  (w_mid_x[j+2:j]),
            .i_down (w_dn_x[j+2:j]),
            .o_next (w_lane[j])
        );
    end

    assign o_next = w_lane & i_mask;

endmodule

// File: dv/testbench.sv
// Self-checking testbench of the life grid step block: row write, row read and B3/S23 advance.
`timescale 1ns / 100ps

module testbench;
    import lgs_pkg::*;

    // Generous cycle cap. The slowest correct run is about 450 transactions, each at worst an
    // advance over 64 rows plus sender gaps and receiver stalls, and one long
    // receiver hold.
    localparam int LIMIT_CYCLES = 250000;
    localparam int HOLD_CYCLES  = 300;
    // Cycles to let pass after the last result.
    localparam int TAIL_CYCLES  = 70;

    // One result of the block, as the grid predictor expects it
    typedef struct packed {
        t_row bits;
        t_req kind;
    } t_row_ack;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [6:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;   // [5:0] row_index, [69:6] row_bits_in, [71:70] zero
    logic [1:0]  i_s_tuser;   // [1:0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;   // [63:0] row_bits_out
    logic [1:0]  o_m_tuser;   // [1:0] ack_kind

    life_automaton_grid_step DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_row_ack   pending_acks[$];  // expected results, oldest first
    int         err_cnt     = 0;
    int         sent_cnt    = 0;
    int         cycle_cnt   = 0;
    int         send_idle_pct  = 0;  // chance per cycle that the sender stays idle
    int         recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    logic       recv_hold   = 1'b0;  // long receiver hold-off, set by its own process
    event       hold_start;

    // Grid predictor: own copy of the cells and of both size registers
    t_row       life_grid [MAX_ROWS];
    logic [6:0] life_rows_cfg;
    logic [6:0] life_cols_cfg;

    // ------------------------------------------------------------------
    // Clock and cycle cap
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Grid predictor
    // ------------------------------------------------------------------
    // Rows in use: the register saturates at the grid height, 0 means no rows.
    function automatic int life_rows();
        return (life_rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(life_rows_cfg);
    endfunction

    // Column mask: low bits set for the columns in use, saturating at the row width.
    function automatic t_row life_mask();
        int c;
        c = (life_cols_cfg > MAX_COLS) ? MAX_COLS : int'(life_cols_cfg);
        if (c >= ROW_W)
            return '1;
        return (t_row'(1) << c) - t_row'(1);
    endfunction

    // Next generation of one row from the old rows above, at and below it.
    // Shifts bring each of the 8 neighbours into column j; zeros shift in at the edges,
    // so the grid does not wrap.
    function automatic t_row life_next_row(t_row up, t_row mid, t_row dn, t_row mask);
        t_row nb [8];
        t_row res;
        int   n;
        nb[0] = up << 1;  nb[1] = up;  nb[2] = up >> 1;
        nb[3] = mid << 1;              nb[4] = mid >> 1;
        nb[5] = dn << 1;  nb[6] = dn;  nb[7] = dn >> 1;
        res = '0;
        for (int j = 0; j < ROW_W; j++) begin
            n = 0;
            for (int k = 0; k < 8; k++)
                n += int'(nb[k][j]);
            if (n == BIRTH_CNT || (mid[j] && n == SURVIVE_CNT))
                res[j] = 1'b1;
        end
        return res & mask;
    endfunction

    // Whole-grid advance; rows outside the area keep their content and count as dead.
    function automatic void life_advance();
        t_row mask;
        t_row above;
        t_row cur;
        t_row below;
        int   rows;
        rows  = life_rows();
        mask  = life_mask();
        above = '0;
        for (int r = 0; r < rows; r++) begin
            below = (r + 1 < rows) ? (life_grid[r+1] & mask) : '0;
            cur   = life_grid[r] & mask;
            life_grid[r] = life_next_row(above, cur, below, mask);
            above = cur;
        end
    endfunction

    // Apply one request to the predicted grid and return the result it causes.
    function automatic t_row_ack life_apply_req(t_req kind, logic [5:0] row, t_row bits);
        t_row_ack ack;
        logic     in_area;
        in_area  = int'(row) < life_rows();
        ack.bits = '0;
        ack.kind = kind;
        case (kind)
            REQ_WRITE: begin
                if (in_area)
                    life_grid[row] = bits & life_mask();
            end
            REQ_READ: begin
                if (in_area)
                    ack.bits = life_grid[row] & life_mask();
            end
            REQ_ADVANCE: begin
                life_advance();
            end
            default: begin
                // unknown request: grid untouched, kind echoed as the error code
            end
        endcase
        return ack;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------
    // tready changes at the falling edge; random stalls plus the long hold-off.
    always @(negedge i_clk) begin
        i_m_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Long hold-off, counted here so the sender keeps offering transactions meanwhile
    initial begin
        forever begin
            @(hold_start);
            recv_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            recv_hold = 1'b0;
        end
    end

    task automatic report_mismatch(string msg);
        err_cnt++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_row_ack exp_ack;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_acks.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: bits %h kind %0d",
                                          o_m_tdata, o_m_tuser));
            end else begin
                exp_ack = pending_acks.pop_front();
                if (o_m_tuser !== exp_ack.kind)
                    report_mismatch($sformatf("ack_kind %0d, expected %0d",
                                              o_m_tuser, exp_ack.kind));
                if (o_m_tdata !== exp_ack.bits)
                    report_mismatch($sformatf("row_bits_out %h, expected %h (kind %0d)",
                                              o_m_tdata, exp_ack.bits, exp_ack.kind));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Send one request. Called right after a rising edge (or at a falling edge); returns
    // at the rising edge that accepted the transaction. tvalid stays high into the next
    // call, so back-to-back requests drop valid in between only when the sender idles.
    task automatic send_req(t_req kind, logic [5:0] row, t_row bits);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {2'b00, bits, row};
        i_s_tuser  = kind;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pending_acks.push_back(life_apply_req(kind, row, bits));
        sent_cnt++;
    endtask

    // Wait until every expected result has come back, with the request side idle.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_acks.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Size register write, only with the block idle
    task automatic write_cfg(logic idx, logic [6:0] val);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_ROWS)
            life_rows_cfg = val;
        else
            life_cols_cfg = val;
    endtask

    function automatic t_row rand_row();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Grid reads as all dead after reset, with the reset size of 50 x 60
    task automatic test_reset_state();
        send_req(REQ_READ, 6'd0,  '0);
        send_req(REQ_READ, 6'd49, '0);
        send_req(REQ_READ, 6'd63, '0);  // beyond the reset row count
    endtask

    // Full 64 x 64 grid: corner rows, all-ones data, unknown request, one advance
    task automatic test_full_grid();
        write_cfg(CFG_ROWS, 7'd64);
        write_cfg(CFG_COLS, 7'd64);
        send_req(REQ_WRITE,   6'd0,  '1);
        send_req(REQ_WRITE,   6'd63, '1);
        send_req(REQ_READ,    6'd0,  '0);
        send_req(REQ_READ,    6'd63, '1);
        send_req(REQ_BAD,     6'd5,  '1);  // must change nothing
        send_req(REQ_ADVANCE, 6'd63, '1);
        send_req(REQ_READ,    6'd0,  '0);
        send_req(REQ_READ,    6'd1,  '0);
        send_req(REQ_READ,    6'd63, '0);
    endtask

    // Small 5 x 5 area: write masking, out-of-area write and read, advance at the edges
    task automatic test_small_area();
        write_cfg(CFG_ROWS, 7'd5);
        write_cfg(CFG_COLS, 7'd5);
        send_req(REQ_WRITE,   6'd2, '1);   // bits above column 4 dropped
        send_req(REQ_READ,    6'd2, '0);
        send_req(REQ_WRITE,   6'd7, '1);   // outside the area: ignored
        send_req(REQ_READ,    6'd7, '0);
        send_req(REQ_ADVANCE, 6'd0, '0);
        send_req(REQ_READ,    6'd1, '0);
        send_req(REQ_READ,    6'd3, '0);
    endtask

    // Register values outside the nominal range: zero gives an empty area, above max saturates
    task automatic test_size_limits();
        write_cfg(CFG_ROWS, 7'd0);
        write_cfg(CFG_COLS, 7'd127);
        send_req(REQ_WRITE,   6'd0,  '1);
        send_req(REQ_READ,    6'd0,  '0);
        send_req(REQ_ADVANCE, 6'd0,  '0);
        write_cfg(CFG_ROWS, 7'd127);
        write_cfg(CFG_COLS, 7'd0);
        send_req(REQ_READ,    6'd63, '0);  // no columns: reads as zero
        send_req(REQ_WRITE,   6'd10, '1);  // stored fully masked
        write_cfg(CFG_COLS, 7'd127);
        send_req(REQ_READ,    6'd63, '0);  // row 63 kept its earlier content
        send_req(REQ_READ,    6'd10, '0);
    endtask

    // Mostly well-formed episodes (seed rows, advance, read back) with some noise
    // transactions: unknown request codes and row indexes outside the area.
    task automatic run_life_episodes(int n_items);
        int   stop_at;
        int   rows;
        t_row bits;
        stop_at = sent_cnt + n_items;
        while (sent_cnt < stop_at) begin
            rows = life_rows();
            if ($urandom_range(0, 9) < 8 && rows > 0) begin
                repeat ($urandom_range(1, (rows < 6) ? rows : 6)) begin
                    bits = rand_row();
                    if ($urandom_range(0, 1))
                        bits &= rand_row();  // sparser rows keep patterns alive longer
                    send_req(REQ_WRITE, 6'($urandom_range(0, rows - 1)), bits);
                end
                repeat ($urandom_range(1, 3))
                    send_req(REQ_ADVANCE, 6'($urandom_range(0, 63)), rand_row());
                repeat ($urandom_range(2, 4))
                    send_req(REQ_READ, 6'($urandom_range(0, rows - 1)), rand_row());
            end else begin
                repeat ($urandom_range(1, 4))
                    send_req(t_req'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             rand_row());
            end
        end
    endtask

    // Random traffic under four idling phases, two grid sizes per phase
    task automatic test_random_traffic();
        int send_pct [4] = '{0, 79, 0, 22};
        int recv_pct [4] = '{0, 0, 79, 22};
        int rows_set [8] = '{12, 64, 3, 20, 64, 7, 1, 16};
        int cols_set [8] = '{64, 17, 1, 63, 64, 40, 64, 5};
        for (int p = 0; p < 4; p++) begin
            for (int s = 0; s < 2; s++) begin
                write_cfg(CFG_ROWS, 7'(rows_set[2*p+s]));
                write_cfg(CFG_COLS, 7'(cols_set[2*p+s]));
                send_idle_pct  = send_pct[p];
                recv_stall_pct = recv_pct[p];
                run_life_episodes(45);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off for a long stretch while requests keep coming: output register
    // and the request in work fill up, and the block has to stall its input.
    task automatic test_backpressure();
        write_cfg(CFG_ROWS, 7'd8);
        write_cfg(CFG_COLS, 7'd64);
        -> hold_start;
        repeat (4)
            send_req(REQ_WRITE, 6'($urandom_range(0, 7)), rand_row());
        send_req(REQ_ADVANCE, 6'd0, '0);
        repeat (6)
            send_req(REQ_READ, 6'($urandom_range(0, 7)), '0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_ROWS;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = REQ_WRITE;
        // predictor at reset: 50 x 60 area, all cells dead
        life_rows_cfg = 7'd50;
        life_cols_cfg = 7'd60;
        for (int r = 0; r < MAX_ROWS; r++)
            life_grid[r] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_full_grid();
        test_small_area();
        test_size_limits();
        test_random_traffic();
        test_backpressure();

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
